@@ design/cbm_pkg.sv @@
// shared types, codes and helpers for the cartridge bank mapper
`default_nettype none

package cbm_pkg;

    localparam int CHR_SLOTS = 8;

    typedef logic [8:0] chr_bank_t;
    typedef logic [CHR_SLOTS-1:0][8:0] chr_banks_t;

    // request kinds
    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    // cpu register selects, address bits 15:11
    localparam logic [4:0] REG_CHR01  = 5'h11;
    localparam logic [4:0] REG_CHR23  = 5'h13;
    localparam logic [4:0] REG_CHR45  = 5'h15;
    localparam logic [4:0] REG_CHR67  = 5'h17;
    localparam logic [4:0] REG_IRQ_LD = 5'h19;
    localparam logic [4:0] REG_IRQ_EN = 5'h1B;
    localparam logic [4:0] REG_MIRROR = 5'h1D;
    localparam logic [4:0] REG_PRG    = 5'h1F;

    localparam int         IRQ_EN_BIT  = 4;
    localparam logic [7:0] IRQ_FIRE_AT = 8'hF7;
    localparam logic [8:0] LAST_LINE   = 9'd239;

    // config register
    localparam logic [8:0] BANK_TOTAL_RESET = 9'd8;
    localparam logic       CFG_IDX_TOTAL    = 1'b0;

    typedef struct packed {
        chr_banks_t chr;
        logic [7:0] prg;
        logic [1:0] mirror;
        logic       irq_en;
        logic [7:0] irq_cnt;
        logic [7:0] irq_rel;
    } map_state_t;

    typedef struct packed {
        logic       irq;
        chr_banks_t chr;
        logic [7:0] prg;
        logic [1:0] mirror;
    } map_result_t;

    function automatic chr_banks_t boot_banks(input logic [8:0] total);
        chr_banks_t b;
        for (int i = 0; i < 4; i++)
        begin
            b[i]     = 9'(i);
            b[i + 4] = total - 9'd4 + 9'(i);
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ design/cartridge_bank_mapper_scanline_irq_unit.sv @@
// top level of the cartridge bank mapper with scanline irq counter
//
// requests enter on the s_axis stream: tuser carries the kind (mapper
// reset, cpu register write, scanline event), tdata the address, data
// byte, scanline number and rendering flag. each request yields one
// result on the m_axis stream: the irq pulse, all eight pattern banks,
// the program bank pair and the mirroring code as they stand after it.
// m_axis_tvalid rises in the cycle after accept; one request per cycle
// is sustained while m_axis_tready stays high, since the whole update is
// one pass of logic from the state registers into the result register.
// when the receiver stalls, the result register holds and s_axis_tready
// drops until it is taken; a request can still enter in the cycle its
// predecessor leaves.
// reset clears the output valid, loads pattern banks 0-7 and clears the
// irq registers; rom_bank_total returns to 8. rom_bank_total is written
// over the apb port at addresses 0-3 and sets the upper banks of later
// mapper reset requests.
`default_nettype none

module cartridge_bank_mapper_scanline_irq_unit
    import cbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // addr, data, scanline, rendering, pad
    input  wire logic [1:0]  s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [87:0] m_axis_tdata,   // irq, chr_bank_a..h, prg_pair, mirror_mode, pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic        accept;
    logic [8:0]  bank_total;
    map_result_t result;
    map_result_t out_result;

    assign accept = s_axis_tvalid && s_axis_tready;

    cbm_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .bank_total (bank_total)
    );

    cbm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .op         (s_axis_tuser),
        .addr       (s_axis_tdata[15:0]),
        .data       (s_axis_tdata[23:16]),
        .scanline   (s_axis_tdata[33:24]),
        .rendering  (s_axis_tdata[34]),
        .bank_total (bank_total),
        .result     (result)
    );

    cbm_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result     (result),
        .out_ready  (m_axis_tready),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_result (out_result)
    );

    always_comb
    begin
        m_axis_tdata        = '0;
        m_axis_tdata[0]     = out_result.irq;
        for (int i = 0; i < CHR_SLOTS; i++)
        begin
            m_axis_tdata[1 + 9*i +: 9] = out_result.chr[i];
        end
        m_axis_tdata[80:73] = out_result.prg;
        m_axis_tdata[82:81] = out_result.mirror;
    end

    // every accepted request produces a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted request gave no result");

    // only scanline events raise irq
    a_irq_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_axis_tuser != OP_SCAN) |=> !m_axis_tdata[0])
        else $error("irq raised by a non-scanline request");

    // a mapper reset puts bank 0 at 0 and bank 1 at 1
    a_reset_banks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_axis_tuser == OP_RESET)
        |=> (m_axis_tdata[9:1] == 9'd0) && (m_axis_tdata[18:10] == 9'd1))
        else $error("mapper reset left wrong low banks");

endmodule

`default_nettype wire

@@ design/cbm_cfg.sv @@
// apb register holding the rom bank total
`default_nettype none

module cbm_cfg
    import cbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [8:0]  bank_total
);

    logic [8:0] total_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_TOTAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= BANK_TOTAL_RESET;
        end
        else if (wr_en)
        begin
            total_reg <= pwdata[8:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == CFG_IDX_TOTAL)
        begin
            prdata = {23'd0, total_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    assign bank_total = total_reg;

endmodule

`default_nettype wire

@@ design/cbm_core.sv @@
// mapper state registers and per-request update logic
`default_nettype none

module cbm_core
    import cbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] addr,
    input  wire logic [7:0]  data,
    input  wire logic [9:0]  scanline,
    input  wire logic        rendering,
    input  wire logic [8:0]  bank_total,
    output map_result_t      result
);

    map_state_t state_reg;
    map_state_t state_next;
    logic       irq;
    logic       line_ok;

    assign line_ok = !scanline[9] && (scanline[8:0] <= LAST_LINE);

    always_comb
    begin
        state_next = state_reg;
        irq        = 1'b0;
        unique case (op)
            OP_RESET:
            begin
                state_next.chr     = boot_banks(bank_total);
                state_next.irq_en  = 1'b0;
                state_next.irq_cnt = 8'd0;
                state_next.irq_rel = 8'd0;
            end
            OP_WRITE:
            begin
                unique case (addr[15:11])
                    REG_CHR01:
                    begin
                        state_next.chr[0] = {data, 1'b0};
                        state_next.chr[1] = {data, 1'b1};
                    end
                    REG_CHR23:
                    begin
                        state_next.chr[2] = {data, 1'b0};
                        state_next.chr[3] = {data, 1'b1};
                    end
                    REG_CHR45:
                    begin
                        state_next.chr[4] = {data, 1'b0};
                        state_next.chr[5] = {data, 1'b1};
                    end
                    REG_CHR67:
                    begin
                        state_next.chr[6] = {data, 1'b0};
                        state_next.chr[7] = {data, 1'b1};
                    end
                    REG_IRQ_LD:
                    begin
                        state_next.irq_cnt = state_reg.irq_rel;
                        state_next.irq_rel = data;
                    end
                    REG_IRQ_EN: state_next.irq_en = data[IRQ_EN_BIT];
                    REG_MIRROR: state_next.mirror = data[1:0];
                    REG_PRG:    state_next.prg    = data;
                    default:    ;
                endcase
            end
            OP_SCAN:
            begin
                if (state_reg.irq_en && line_ok && rendering)
                begin
                    if (state_reg.irq_cnt == IRQ_FIRE_AT)
                    begin
                        state_next.irq_cnt = state_reg.irq_rel;
                        irq                = 1'b1;
                    end
                    else
                    begin
                        state_next.irq_cnt = state_reg.irq_cnt - 8'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.chr     <= boot_banks(BANK_TOTAL_RESET);
            state_reg.prg     <= 8'd0;
            state_reg.mirror  <= 2'd0;
            state_reg.irq_en  <= 1'b0;
            state_reg.irq_cnt <= 8'd0;
            state_reg.irq_rel <= 8'd0;
        end
        else if (load)
        begin
            state_reg <= state_next;
        end
    end

    assign result.irq    = irq;
    assign result.chr    = state_next.chr;
    assign result.prg    = state_next.prg;
    assign result.mirror = state_next.mirror;

endmodule

`default_nettype wire

@@ design/cbm_out.sv @@
// result register with valid flag and back-pressure
`default_nettype none

module cbm_out
    import cbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire map_result_t result,
    input  wire logic        out_ready,
    output logic             in_ready,
    output logic             out_valid,
    output map_result_t      out_result
);

    logic        valid_reg;
    map_result_t res_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = res_reg;

endmodule

`default_nettype wire

@@ test/tb_mapper_pkg.sv @@
// bank mapper tracking model and result checking for the mapper testbench
package tb_mapper_pkg;

    import cbm_pkg::*;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam logic [7:0] IRQ_RELOAD_AT = 8'hF6;
    localparam int         LAST_VISIBLE  = 239;

    typedef struct packed {
        logic       irq;
        chr_banks_t chr;
        logic [7:0] prg;
        logic [1:0] mirror;
    } bank_view_t;

    class bank_map_tracker;
        logic [8:0] bank_total;
        chr_banks_t chr;
        logic [7:0] prg;
        logic [1:0] mirror;
        logic       irq_en;
        logic [7:0] irq_cnt;
        logic [7:0] irq_rel;
        bank_view_t expected_views[$];
        int unsigned mismatches;

        function new();
            bank_total = 9'd8;
            prg = '0;
            mirror = '0;
            mismatches = 0;
            reload_banks();
        endfunction

        function void reload_banks();
            for (int i = 0; i < 4; i++)
            begin
                chr[i]     = 9'(i);
                chr[i + 4] = bank_total - 9'd4 + 9'(i);
            end
            irq_en = 1'b0;
            irq_cnt = '0;
            irq_rel = '0;
        endfunction

        function void set_pair(input int first, input logic [7:0] data);
            chr[first]     = {data, 1'b0};
            chr[first + 1] = {data, 1'b1};
        endfunction

        function void take_request(input logic [1:0] op, input logic [15:0] addr,
                                   input logic [7:0] data, input logic [9:0] line,
                                   input logic rend);
            bank_view_t view;
            view.irq = 1'b0;
            case (op)
                OP_RESET:
                    reload_banks();
                OP_WRITE:
                    case (addr[15:11])
                        REG_CHR01:  set_pair(0, data);
                        REG_CHR23:  set_pair(2, data);
                        REG_CHR45:  set_pair(4, data);
                        REG_CHR67:  set_pair(6, data);
                        REG_IRQ_LD:
                        begin
                            irq_cnt = irq_rel;
                            irq_rel = data;
                        end
                        REG_IRQ_EN: irq_en = data[IRQ_EN_BIT];
                        REG_MIRROR: mirror = data[1:0];
                        REG_PRG:    prg = data;
                        default: ;
                    endcase
                OP_SCAN:
                    if (irq_en && rend && $signed(line) >= 0 && $signed(line) <= LAST_VISIBLE)
                    begin
                        irq_cnt = irq_cnt - 8'd1;
                        if (irq_cnt == IRQ_RELOAD_AT)
                        begin
                            irq_cnt = irq_rel;
                            view.irq = 1'b1;
                        end
                    end
                default: ;
            endcase
            view.chr = chr;
            view.prg = prg;
            view.mirror = mirror;
            expected_views.push_back(view);
        endfunction

        function void check_result(input logic [87:0] tdata);
            bank_view_t want;
            logic [8:0] got_bank;
            if (expected_views.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, tdata);
                mismatches++;
                return;
            end
            want = expected_views.pop_front();
            if (tdata[0] !== want.irq)
            begin
                $display("%0t: irq expected %b actual %b", $realtime, want.irq, tdata[0]);
                mismatches++;
            end
            for (int i = 0; i < CHR_SLOTS; i++)
            begin
                got_bank = tdata[1 + 9 * i +: 9];
                if (got_bank !== want.chr[i])
                begin
                    $display("%0t: chr bank %0d expected %0d actual %0d",
                             $realtime, i, want.chr[i], got_bank);
                    mismatches++;
                end
            end
            if (tdata[80:73] !== want.prg)
            begin
                $display("%0t: prg pair expected %0d actual %0d",
                         $realtime, want.prg, tdata[80:73]);
                mismatches++;
            end
            if (tdata[82:81] !== want.mirror)
            begin
                $display("%0t: mirror expected %0d actual %0d",
                         $realtime, want.mirror, tdata[82:81]);
                mismatches++;
            end
        endfunction
    endclass

endpackage

@@ test/tb_top.sv @@
// testbench top for the cartridge bank mapper with scanline irq counter
module tb_top;

    import cbm_pkg::*;
    import tb_mapper_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] BANK_TOTAL_ADDR = 3'd0;
    localparam int         HOLD_CYCLES     = 60;
    localparam int         PHASE_ITEMS     = 165;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // addr, data, scanline, rendering, pad
    logic [1:0]  s_axis_tuser = '0;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;        // irq, chr_bank_a..h, prg_pair, mirror_mode, pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_due = 1'b0;

    bank_map_tracker tracker = new();

    cartridge_bank_mapper_scanline_irq_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver side, with one long hold-off on demand
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_due)
            begin
                hold_due = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);
    end

    task automatic send_request(input logic [1:0] op, input logic [15:0] addr,
                                input logic [7:0] data, input logic [9:0] line,
                                input logic rend);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {5'b0, rend, line, data, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_request(op, addr, data, line, rend);
    endtask

    task automatic send_random_request();
        int pick;
        logic [1:0] op;
        logic [4:0] sel;
        logic [15:0] addr;
        logic [7:0] data;
        logic [9:0] line;
        logic rend;
        pick = $urandom_range(99);
        addr = 16'($urandom);
        data = 8'($urandom);
        rend = ($urandom_range(9) != 0);
        if ($urandom_range(9) == 0)
            line = 10'($urandom);
        else if ($urandom_range(4) == 0)
            line = 10'($urandom_range(262)) - 10'd1;
        else
            line = 10'($urandom_range(LAST_VISIBLE));
        if (pick < 4)
            op = OP_RESET;
        else if (pick < 6)
            op = OP_NONE;
        else if (pick < 50)
            op = OP_WRITE;
        else
            op = OP_SCAN;
        if (op == OP_WRITE && $urandom_range(6) != 0)
        begin
            case ($urandom_range(7))
                0: sel = REG_CHR01;
                1: sel = REG_CHR23;
                2: sel = REG_CHR45;
                3: sel = REG_CHR67;
                4: sel = REG_IRQ_LD;
                5: sel = REG_IRQ_EN;
                6: sel = REG_MIRROR;
                default: sel = REG_PRG;
            endcase
            addr[15:11] = sel;
            // reload values near the fire point keep irqs coming
            if (sel == REG_IRQ_LD && $urandom_range(9) < 7)
                data = $urandom_range(1) ? 8'($urandom_range(255, 240)) : 8'($urandom_range(16));
            if (sel == REG_IRQ_EN)
                data[IRQ_EN_BIT] = ($urandom_range(3) != 0);
        end
        send_request(op, addr, data, line, rend);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (tracker.expected_views.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bank_total(input logic [8:0] total);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= BANK_TOTAL_ADDR;
        pwdata <= 32'(total);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(total))
        begin
            $display("%0t: bank total readback expected %0d actual %0d",
                     $realtime, total, prdata);
            tracker.mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        tracker.bank_total = total;
    endtask

    initial
    begin
        logic [8:0] totals [6];
        totals = '{9'd4, 9'd256, 9'd0, 9'd511, 9'd3, 9'($urandom_range(256, 4))};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 56;
        send_request(OP_SCAN, 16'h0000, 8'h00, 10'd5, 1'b1);
        send_request(OP_WRITE, 16'h8800, 8'hFF, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'h9FFF, 8'h00, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'hA800, 8'h80, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'hB800, 8'h7F, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'hF800, 8'hFF, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'hE800, 8'hFF, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'h0000, 8'hFF, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'h8000, 8'h55, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'hC800, 8'hFB, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'hC800, 8'hFF, 10'd0, 1'b0);
        send_request(OP_WRITE, 16'hD800, 8'h10, 10'd0, 1'b0);
        // lines -1, 240 and 261, then rendering off: all ignored
        send_request(OP_SCAN, 16'hFFFF, 8'hFF, 10'h3FF, 1'b1);
        send_request(OP_SCAN, 16'h0000, 8'h00, 10'd240, 1'b1);
        send_request(OP_SCAN, 16'h0000, 8'h00, 10'd261, 1'b1);
        send_request(OP_SCAN, 16'h0000, 8'h00, 10'd0, 1'b0);
        // five counted lines reach the fire point
        send_request(OP_SCAN, 16'h0000, 8'h00, 10'd0, 1'b1);
        send_request(OP_SCAN, 16'h0000, 8'h00, 10'd239, 1'b1);
        send_request(OP_SCAN, 16'h0000, 8'h00, 10'd100, 1'b1);
        send_request(OP_SCAN, 16'h0000, 8'h00, 10'd1, 1'b1);
        send_request(OP_SCAN, 16'h0000, 8'h00, 10'd238, 1'b1);
        send_request(OP_NONE, 16'hFFFF, 8'hFF, 10'h3FF, 1'b1);
        send_request(OP_WRITE, 16'hD800, 8'hEF, 10'd0, 1'b0);
        send_request(OP_RESET, 16'h0000, 8'h00, 10'd0, 1'b0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_bank_total(totals[phase]);
            send_request(OP_RESET, 16'($urandom), 8'($urandom), 10'($urandom), 1'b1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 0 && n == 40)
                    hold_due = 1'b1;
                send_random_request();
            end
            drain();
        end

        if (tracker.mismatches == 0 && tracker.expected_views.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
design/cbm_pkg.sv
design/cbm_cfg.sv
design/cbm_core.sv
design/cbm_out.sv
design/cartridge_bank_mapper_scanline_irq_unit.sv
test/tb_mapper_pkg.sv
test/tb_top.sv
